// File: hdl/hab_pkg.sv
// Shared types, constants and command codes for the hashed address blocklist.
`default_nettype none
package hab_pkg;

  localparam int KEY_W           = 32;
  localparam int ENTRY_W         = 9;
  localparam int DEF_MAX_ENTRIES = 256;
  localparam int DEF_TABLE_SLOTS = 512;

  // Knuth multiply and murmur3 finalizer multipliers
  localparam logic [31:0] HASH_MUL0 = 32'd2654435761;
  localparam logic [31:0] HASH_MUL1 = 32'h85EBCA6B;
  localparam logic [31:0] HASH_MUL2 = 32'hC2B2AE35;
  localparam int          HASH_SH_A = 16;
  localparam int          HASH_SH_B = 13;

  typedef enum logic [1:0] {
    MODE_LOOKUP = 2'd0,
    MODE_INSERT = 2'd1,
    MODE_REMOVE = 2'd2,
    MODE_CLEAR  = 2'd3
  } mode_t;

  typedef struct packed {
    mode_t             mode;
    logic [KEY_W-1:0]  key;
  } hab_in_t;

  typedef struct packed {
    logic               hit;
    logic [ENTRY_W-1:0] entry_count;
    logic               evicted;
    logic [KEY_W-1:0]   evicted_key;
  } hab_out_t;

  // Datapath commands issued by the controller, one per cycle
  typedef enum logic [4:0] {
    CMD_NOP,
    CMD_ACCEPT,
    CMD_SET_HOME,
    CMD_RD_POS,
    CMD_POS_ADV,
    CMD_LOC_HIT,
    CMD_INS_BEGIN,
    CMD_INS_WRITE,
    CMD_EV_INIT,
    CMD_CUR_ADV,
    CMD_EV_TAKE,
    CMD_ER_INIT,
    CMD_SCAN_RD,
    CMD_HASH_V,
    CMD_SHIFT,
    CMD_ER_END,
    CMD_CLR_INIT,
    CMD_CLR_WR,
    CMD_EMIT
  } cmd_t;

  // Datapath status seen by the controller
  typedef struct packed {
    logic  key_zero;
    logic  hit;
    logic  rd_zero;
    logic  rd_match;
    logic  n_full;
    logic  full;
    logic  clr_last;
    logic  hash_done;
    logic  out_busy;
    mode_t mode;
  } hab_stat_t;

endpackage
`default_nettype wire

// File: hdl/hab_hash.sv
// Multicycle home-slot hash: Knuth multiply then fmix32 on one shared multiplier.
`default_nettype none
module hab_hash #(
  parameter int TABLE_SLOTS = hab_pkg::DEF_TABLE_SLOTS
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [hab_pkg::KEY_W-1:0]  key,
  output logic                            done,
  output logic [$clog2(TABLE_SLOTS)-1:0]  home
);
  localparam int AW = $clog2(TABLE_SLOTS);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL0 = 2'd1;
  localparam logic [1:0] ST_MUL1 = 2'd2;
  localparam logic [1:0] ST_MUL2 = 2'd3;

  logic [31:0] x_r, x_nxt;
  logic [1:0]  step_r, step_nxt;
  logic        done_r, done_nxt;
  logic [31:0] mul_a, mul_b, prod, fin;

  // Select multiplier operands for the current round
  always_comb begin
    mul_a = x_r;
    mul_b = hab_pkg::HASH_MUL0;
    unique case (step_r)
      ST_MUL1: begin
        mul_a = x_r ^ (x_r >> hab_pkg::HASH_SH_A);
        mul_b = hab_pkg::HASH_MUL1;
      end
      ST_MUL2: begin
        mul_a = x_r ^ (x_r >> hab_pkg::HASH_SH_B);
        mul_b = hab_pkg::HASH_MUL2;
      end
      default: begin
        mul_a = x_r;
        mul_b = hab_pkg::HASH_MUL0;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  // Advance the rounds
  always_comb begin
    x_nxt    = x_r;
    step_nxt = step_r;
    done_nxt = done_r;
    if (start) begin
      x_nxt    = key;
      step_nxt = ST_MUL0;
      done_nxt = 1'b0;
    end else if (step_r != ST_IDLE) begin
      x_nxt    = prod;
      step_nxt = (step_r == ST_MUL2) ? ST_IDLE : step_r + 2'd1;
      done_nxt = (step_r == ST_MUL2);
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt;
    if (!rst_n) begin
      step_r <= ST_IDLE;
      done_r <= 1'b0;
    end else begin
      step_r <= step_nxt;
      done_r <= done_nxt;
    end
  end

  assign fin  = x_r ^ (x_r >> hab_pkg::HASH_SH_A);
  assign home = fin[AW-1:0];
  assign done = done_r;

endmodule
`default_nettype wire

// File: hdl/hab_dp.sv
// Datapath: slot memory, probe registers, counters, hash unit and result register.
`default_nettype none
module hab_dp #(
  parameter int MAX_ENTRIES = hab_pkg::DEF_MAX_ENTRIES,
  parameter int TABLE_SLOTS = hab_pkg::DEF_TABLE_SLOTS
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire hab_pkg::cmd_t     cmd,
  output hab_pkg::hab_stat_t     stat,
  input  wire hab_pkg::hab_in_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output hab_pkg::hab_out_t      out_data
);
  localparam int AW = $clog2(TABLE_SLOTS);
  localparam int CW = $clog2(TABLE_SLOTS + 1);

  logic [hab_pkg::KEY_W-1:0] mem [TABLE_SLOTS];
  logic [hab_pkg::KEY_W-1:0] rdata_r;

  logic [hab_pkg::KEY_W-1:0] key_r, key_nxt, v_r, v_nxt, evkey_r, evkey_nxt;
  hab_pkg::mode_t            mode_r, mode_nxt;
  logic [AW-1:0] home_r, home_nxt, pos_r, pos_nxt, hole_r, hole_nxt;
  logic [AW-1:0] scan_r, scan_nxt, cursor_r, cursor_nxt;
  logic [CW-1:0] n_r, n_nxt, count_r, count_nxt;
  logic          hit_r, hit_nxt, ev_r, ev_nxt;
  logic          out_valid_r, out_valid_nxt;
  hab_pkg::hab_out_t out_r, out_nxt;

  logic                      we, re;
  logic [AW-1:0]             waddr, raddr;
  logic [hab_pkg::KEY_W-1:0] wdata;

  logic                      h_start, h_done;
  logic [hab_pkg::KEY_W-1:0] h_key;
  logic [AW-1:0]             h_home;
  logic [AW-1:0]             d_hole, d_scan, cur_inc, scan_inc;
  logic                      shift_ok;
  logic [31:0]               cnt32;

  hab_hash #(.TABLE_SLOTS(TABLE_SLOTS)) u_hash (
    .clk   (clk),
    .rst_n (rst_n),
    .start (h_start),
    .key   (h_key),
    .done  (h_done),
    .home  (h_home)
  );

  assign h_start  = (cmd == hab_pkg::CMD_ACCEPT) || (cmd == hab_pkg::CMD_HASH_V);
  assign h_key    = (cmd == hab_pkg::CMD_ACCEPT) ? in_data.key : rdata_r;
  assign cur_inc  = cursor_r + AW'(1);
  assign scan_inc = scan_r + AW'(1);
  assign d_hole   = hole_r - h_home;
  assign d_scan   = scan_r - h_home;
  assign shift_ok = (d_hole <= d_scan);
  assign cnt32    = 32'(count_r);

  // Decode memory port controls
  always_comb begin
    we    = 1'b0;
    waddr = pos_r;
    wdata = '0;
    re    = 1'b0;
    raddr = pos_r;
    unique case (cmd)
      hab_pkg::CMD_RD_POS:  begin re = 1'b1; raddr = pos_r; end
      hab_pkg::CMD_CUR_ADV: begin re = 1'b1; raddr = cur_inc; end
      hab_pkg::CMD_SCAN_RD: begin re = 1'b1; raddr = scan_inc; end
      hab_pkg::CMD_INS_WRITE: begin we = 1'b1; waddr = pos_r; wdata = key_r; end
      hab_pkg::CMD_SHIFT:   begin we = shift_ok; waddr = hole_r; wdata = v_r; end
      hab_pkg::CMD_ER_END:  begin we = 1'b1; waddr = hole_r; end
      hab_pkg::CMD_CLR_WR:  begin we = 1'b1; waddr = pos_r; end
      default: begin
        we = 1'b0;
        re = 1'b0;
      end
    endcase
  end

  // Slot memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  // Execute the command
  always_comb begin
    key_nxt    = key_r;
    mode_nxt   = mode_r;
    v_nxt      = v_r;
    evkey_nxt  = evkey_r;
    home_nxt   = home_r;
    pos_nxt    = pos_r;
    hole_nxt   = hole_r;
    scan_nxt   = scan_r;
    cursor_nxt = cursor_r;
    n_nxt      = n_r;
    count_nxt  = count_r;
    hit_nxt    = hit_r;
    ev_nxt     = ev_r;
    out_nxt    = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (cmd)
      hab_pkg::CMD_ACCEPT: begin
        key_nxt   = in_data.key;
        mode_nxt  = in_data.mode;
        hit_nxt   = 1'b0;
        ev_nxt    = 1'b0;
        evkey_nxt = '0;
      end
      hab_pkg::CMD_SET_HOME: begin
        home_nxt = h_home;
        pos_nxt  = h_home;
        n_nxt    = '0;
      end
      hab_pkg::CMD_POS_ADV: begin
        pos_nxt = pos_r + AW'(1);
        n_nxt   = n_r + CW'(1);
      end
      hab_pkg::CMD_LOC_HIT: begin
        hit_nxt  = 1'b1;
        hole_nxt = pos_r;
      end
      hab_pkg::CMD_INS_BEGIN: begin
        pos_nxt = home_r;
        n_nxt   = '0;
      end
      hab_pkg::CMD_INS_WRITE: count_nxt = count_r + CW'(1);
      hab_pkg::CMD_EV_INIT:   n_nxt = '0;
      hab_pkg::CMD_CUR_ADV: begin
        cursor_nxt = cur_inc;
        n_nxt      = n_r + CW'(1);
      end
      hab_pkg::CMD_EV_TAKE: begin
        ev_nxt    = 1'b1;
        evkey_nxt = rdata_r;
        hole_nxt  = cursor_r;
        scan_nxt  = cursor_r;
        n_nxt     = CW'(1);
      end
      hab_pkg::CMD_ER_INIT: begin
        scan_nxt = hole_r;
        n_nxt    = CW'(1);
      end
      hab_pkg::CMD_SCAN_RD: scan_nxt = scan_inc;
      hab_pkg::CMD_HASH_V:  v_nxt = rdata_r;
      hab_pkg::CMD_SHIFT: begin
        if (shift_ok) begin
          hole_nxt = scan_r;
        end
        n_nxt = n_r + CW'(1);
      end
      hab_pkg::CMD_ER_END: begin
        if (count_r != '0) begin
          count_nxt = count_r - CW'(1);
        end
      end
      hab_pkg::CMD_CLR_INIT: begin
        pos_nxt    = '0;
        count_nxt  = '0;
        cursor_nxt = '0;
      end
      hab_pkg::CMD_CLR_WR: pos_nxt = pos_r + AW'(1);
      hab_pkg::CMD_EMIT: begin
        out_valid_nxt       = 1'b1;
        out_nxt.hit         = hit_r;
        out_nxt.entry_count = cnt32[hab_pkg::ENTRY_W-1:0];
        out_nxt.evicted     = ev_r;
        out_nxt.evicted_key = evkey_r;
      end
      default: begin
        out_valid_nxt = out_valid_r && out_stall;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    key_r   <= key_nxt;
    mode_r  <= mode_nxt;
    v_r     <= v_nxt;
    evkey_r <= evkey_nxt;
    home_r  <= home_nxt;
    pos_r   <= pos_nxt;
    hole_r  <= hole_nxt;
    scan_r  <= scan_nxt;
    n_r     <= n_nxt;
    hit_r   <= hit_nxt;
    ev_r    <= ev_nxt;
    out_r   <= out_nxt;
    if (!rst_n) begin
      count_r     <= '0;
      cursor_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      cursor_r    <= cursor_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Report status
  always_comb begin
    stat.key_zero  = (key_r == '0);
    stat.hit       = hit_r;
    stat.rd_zero   = (rdata_r == '0);
    stat.rd_match  = (rdata_r == key_r);
    stat.n_full    = (n_r == CW'(TABLE_SLOTS));
    stat.full      = (cnt32 >= 32'(MAX_ENTRIES)) || (cnt32 >= 32'(TABLE_SLOTS));
    stat.clr_last  = (pos_r == AW'(TABLE_SLOTS - 1));
    stat.hash_done = h_done;
    stat.out_busy  = out_valid_r && out_stall;
    stat.mode      = mode_r;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

// File: hdl/hab_ctrl.sv
// Controller: sequences lookup, insert, eviction, backward-shift erase and clear.
`default_nettype none
module hab_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire hab_pkg::hab_stat_t stat,
  output hab_pkg::cmd_t           cmd
);
  typedef enum logic [4:0] {
    S_RCLR_I, S_RCLR, S_IDLE, S_HWAIT, S_L_RD, S_L_CHK, S_DISP,
    S_EV_ADV, S_EV_CHK, S_ER_N, S_ER_CHK, S_ER_HW, S_ER_END,
    S_INSB, S_I_RD, S_I_CHK, S_CLR, S_DONE
  } state_t;

  state_t state_r, state_nxt;

  // Next state and command
  always_comb begin
    state_nxt = state_r;
    cmd       = hab_pkg::CMD_NOP;
    unique case (state_r)
      S_RCLR_I: begin
        cmd       = hab_pkg::CMD_CLR_INIT;
        state_nxt = S_RCLR;
      end
      S_RCLR: begin
        cmd = hab_pkg::CMD_CLR_WR;
        if (stat.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd       = hab_pkg::CMD_ACCEPT;
          state_nxt = S_HWAIT;
        end
      end
      S_HWAIT: begin
        if (stat.key_zero) begin
          state_nxt = S_DISP;
        end else if (stat.hash_done) begin
          cmd       = hab_pkg::CMD_SET_HOME;
          state_nxt = S_L_RD;
        end
      end
      S_L_RD: begin
        if (stat.n_full) begin
          state_nxt = S_DISP;
        end else begin
          cmd       = hab_pkg::CMD_RD_POS;
          state_nxt = S_L_CHK;
        end
      end
      S_L_CHK: begin
        if (stat.rd_zero) begin
          state_nxt = S_DISP;
        end else if (stat.rd_match) begin
          cmd       = hab_pkg::CMD_LOC_HIT;
          state_nxt = S_DISP;
        end else begin
          cmd       = hab_pkg::CMD_POS_ADV;
          state_nxt = S_L_RD;
        end
      end
      S_DISP: begin
        unique case (stat.mode)
          hab_pkg::MODE_INSERT: begin
            if (stat.key_zero || stat.hit) begin
              state_nxt = S_DONE;
            end else if (stat.full) begin
              cmd       = hab_pkg::CMD_EV_INIT;
              state_nxt = S_EV_ADV;
            end else begin
              state_nxt = S_INSB;
            end
          end
          hab_pkg::MODE_REMOVE: begin
            if (stat.hit) begin
              cmd       = hab_pkg::CMD_ER_INIT;
              state_nxt = S_ER_N;
            end else begin
              state_nxt = S_DONE;
            end
          end
          hab_pkg::MODE_CLEAR: begin
            cmd       = hab_pkg::CMD_CLR_INIT;
            state_nxt = S_CLR;
          end
          default: state_nxt = S_DONE;
        endcase
      end
      S_EV_ADV: begin
        if (stat.n_full) begin
          state_nxt = S_INSB;
        end else begin
          cmd       = hab_pkg::CMD_CUR_ADV;
          state_nxt = S_EV_CHK;
        end
      end
      S_EV_CHK: begin
        if (stat.rd_zero) begin
          state_nxt = S_EV_ADV;
        end else begin
          cmd       = hab_pkg::CMD_EV_TAKE;
          state_nxt = S_ER_N;
        end
      end
      S_ER_N: begin
        if (stat.n_full) begin
          state_nxt = S_ER_END;
        end else begin
          cmd       = hab_pkg::CMD_SCAN_RD;
          state_nxt = S_ER_CHK;
        end
      end
      S_ER_CHK: begin
        if (stat.rd_zero) begin
          state_nxt = S_ER_END;
        end else begin
          cmd       = hab_pkg::CMD_HASH_V;
          state_nxt = S_ER_HW;
        end
      end
      S_ER_HW: begin
        if (stat.hash_done) begin
          cmd       = hab_pkg::CMD_SHIFT;
          state_nxt = S_ER_N;
        end
      end
      S_ER_END: begin
        cmd       = hab_pkg::CMD_ER_END;
        state_nxt = (stat.mode == hab_pkg::MODE_INSERT) ? S_INSB : S_DONE;
      end
      S_INSB: begin
        cmd       = hab_pkg::CMD_INS_BEGIN;
        state_nxt = S_I_RD;
      end
      S_I_RD: begin
        if (stat.n_full) begin
          state_nxt = S_DONE;
        end else begin
          cmd       = hab_pkg::CMD_RD_POS;
          state_nxt = S_I_CHK;
        end
      end
      S_I_CHK: begin
        if (stat.rd_zero) begin
          cmd       = hab_pkg::CMD_INS_WRITE;
          state_nxt = S_DONE;
        end else begin
          cmd       = hab_pkg::CMD_POS_ADV;
          state_nxt = S_I_RD;
        end
      end
      S_CLR: begin
        cmd = hab_pkg::CMD_CLR_WR;
        if (stat.clr_last) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!stat.out_busy) begin
          cmd       = hab_pkg::CMD_EMIT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Hold state; reset starts the clearing sweep
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_RCLR_I;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

endmodule
`default_nettype wire

// File: hdl/hashed_address_blocklist_unit.sv
// A transaction runs from acceptance through the hash and the probe loop to out_valid; each
//   extra probe, eviction cursor step and shifted cluster entry lengthens it, and a zero key
//   goes on without waiting for the hash.
// Only one transaction is taken at a time; the next can be accepted while the result is
//   presented on out_valid.
// Clear writes every slot; reset holds in_stall while it clears every slot.
`default_nettype none
module hashed_address_blocklist_unit #(
  parameter int MAX_ENTRIES = hab_pkg::DEF_MAX_ENTRIES,
  parameter int TABLE_SLOTS = hab_pkg::DEF_TABLE_SLOTS
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire hab_pkg::hab_in_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output hab_pkg::hab_out_t      out_data
);
  hab_pkg::cmd_t      cmd;
  hab_pkg::hab_stat_t stat;

  hab_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  hab_dp #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .TABLE_SLOTS (TABLE_SLOTS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

// File: hdl/hab_check.sv
// Port-level checker for the blocklist unit, bound to the top level.
`default_nettype none
module hab_check (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_stall,
  input wire hab_pkg::hab_in_t  in_data,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire hab_pkg::hab_out_t out_data
);
  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // One transaction in flight at a time
  a_one_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second transaction taken while busy");

  // Eviction key present exactly when an eviction is flagged
  a_ev_key: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.evicted == (out_data.evicted_key != '0)))
    else $error("eviction flag and key disagree");

  // Eviction only on insert of an absent key, which then holds an entry
  a_ev_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.evicted |-> !out_data.hit && (out_data.entry_count != '0))
    else $error("eviction on a hit or with empty table");

endmodule

bind hashed_address_blocklist_unit hab_check u_hab_check (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
`default_nettype wire
